/* hw/rtl/btf_pkg.sv */
// ----------------------------------------------------------------------------
// btf_pkg
// Shared constants and register codes for the Bezier trajectory core.
// ----------------------------------------------------------------------------
package btf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int TIME_BITS_DEF = 20;
    localparam int POS_W         = 24;
    localparam int VEL_W         = 32;
    localparam int CFG_ADDR_W    = 3;
    localparam int DUR_RESET     = 1000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_POINT_ZERO      = 3'd0,
        CFG_POINT_ONE       = 3'd1,
        CFG_POINT_TWO       = 3'd2,
        CFG_POINT_THREE     = 3'd3,
        CFG_PATH_DURATION   = 3'd4,
        CFG_MAX_COEF        = 3'd5,
        CFG_RAMP_UP_END     = 3'd6,
        CFG_RAMP_DOWN_START = 3'd7
    } t_cfg_reg;

endpackage

/* hw/rtl/btf_div.sv */
// ----------------------------------------------------------------------------
// btf_div
// Pipelined restoring divider, one quotient bit per stage, with side data.
// ----------------------------------------------------------------------------
module btf_div #(
    parameter int NW = 32,
    parameter int DW = 16,
    parameter int QW = 16,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    localparam int CW = (DW + QW > NW) ? DW + QW : NW;

    logic [CW-1:0] r_rem  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [SW-1:0] r_side [QW];
    logic [QW-1:0] r_vld;

    for (genvar g = 0; g < QW; g++) begin : g_stage
        localparam int K = QW - 1 - g;
        logic [CW-1:0] w_rem_in;
        logic [DW-1:0] w_den_in;
        logic [QW-1:0] w_quo_in;
        logic [SW-1:0] w_side_in;
        logic          w_vld_in;
        logic [CW:0]   w_trial;
        logic [CW-1:0] n_rem;
        logic [QW-1:0] n_quo;

        if (g == 0) begin : g_first
            assign w_rem_in  = CW'(i_num);
            assign w_den_in  = i_den;
            assign w_quo_in  = '0;
            assign w_side_in = i_side;
            assign w_vld_in  = i_valid;
        end else begin : g_next
            assign w_rem_in  = r_rem[g-1];
            assign w_den_in  = r_den[g-1];
            assign w_quo_in  = r_quo[g-1];
            assign w_side_in = r_side[g-1];
            assign w_vld_in  = r_vld[g-1];
        end

        assign w_trial = {1'b0, w_rem_in} - ({1'b0, CW'(w_den_in)} << K);

        always_comb begin
            n_rem = w_rem_in;
            n_quo = w_quo_in;
            if (!w_trial[CW]) begin
                n_rem = w_trial[CW-1:0];
                n_quo = w_quo_in | (QW'(1) << K);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_den[g]  <= w_den_in;
                r_quo[g]  <= n_quo;
                r_side[g] <= w_side_in;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

/* hw/rtl/bezier_trajectory_with_feedforward_core.sv */
// ----------------------------------------------------------------------------
// bezier_trajectory_with_feedforward_core
// One axis of a cubic Bezier path: position, path velocity and a velocity
// with trapezoidal feedforward, evaluated per time sample.
//
// Channel   Dir  Contents (lowest bits first)
// s_axis    in   tdata: elapsed_ms, base_velocity
// m_axis    out  tdata: position, path_velocity, velocity_out; tuser: envelope_valid
// cfg       in   we, addr, wdata
//
// One request enters per cycle while the output is not stalled. The time divider
// has FRAC_BITS + 1 stages and the velocity divider 32 stages.
// Reset is synchronous, clears all valid bits and loads the configuration defaults.
// The whole pipeline holds while a result waits at the output and the sink
// is not ready; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module bezier_trajectory_with_feedforward_core
    import btf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // elapsed_ms, base_velocity
    input  logic [((TIME_BITS+VEL_W+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // position, path_velocity, velocity_out
    output logic [((POS_W+2*VEL_W+7)/8)*8-1:0]   o_m_axis_tdata,
    // envelope_valid
    output logic                  o_m_axis_tuser,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [((POS_W > TIME_BITS) ? ((POS_W > FRAC_BITS+1) ? POS_W : FRAC_BITS+1)
                  : ((TIME_BITS > FRAC_BITS+1) ? TIME_BITS : FRAC_BITS+1))-1:0] i_cfg_wdata
);

    localparam int F     = FRAC_BITS;
    localparam int UW    = F + 1;
    localparam int BW    = UW + 2;
    localparam int DIFW  = POS_W + 1;
    localparam int TW    = UW + 1 + DIFW;
    localparam int SSW   = TW + 4;
    localparam int PPW   = BW + 1 + POS_W;
    localparam int PSW   = PPW + 2;
    localparam int MKW   = SSW + 10;
    localparam int NW    = MKW - F;
    localparam int PRW   = UW + 1 + VEL_W;
    localparam int VSW   = PRW - F + 1;
    localparam int OUT_W = ((POS_W + 2 * VEL_W + 7) / 8) * 8;
    localparam int PVSW  = POS_W + VEL_W + 2;
    localparam logic [UW-1:0] ONE = UW'(1) << F;
    localparam logic [VEL_W-1:0] VMAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [VEL_W-1:0] VMIN = {1'b1, {(VEL_W-1){1'b0}}};
    localparam logic [POS_W-1:0] PMAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] PMIN = {1'b1, {(POS_W-1){1'b0}}};

    // Configuration
    logic signed [POS_W-1:0] r_p0, r_p1, r_p2, r_p3;
    logic [TIME_BITS-1:0]    r_dur;
    logic [UW-1:0]           r_mc, r_rue, r_rds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0  <= '0;
            r_p1  <= '0;
            r_p2  <= '0;
            r_p3  <= '0;
            r_dur <= TIME_BITS'(DUR_RESET);
            r_mc  <= '0;
            r_rue <= ONE >> 2;
            r_rds <= (ONE >> 1) + (ONE >> 2);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_POINT_ZERO:      r_p0  <= i_cfg_wdata[POS_W-1:0];
                CFG_POINT_ONE:       r_p1  <= i_cfg_wdata[POS_W-1:0];
                CFG_POINT_TWO:       r_p2  <= i_cfg_wdata[POS_W-1:0];
                CFG_POINT_THREE:     r_p3  <= i_cfg_wdata[POS_W-1:0];
                CFG_PATH_DURATION:   r_dur <= i_cfg_wdata[TIME_BITS-1:0];
                CFG_MAX_COEF:        r_mc  <= i_cfg_wdata[UW-1:0];
                CFG_RAMP_UP_END:     r_rue <= i_cfg_wdata[UW-1:0];
                CFG_RAMP_DOWN_START: r_rds <= i_cfg_wdata[UW-1:0];
                default: ;
            endcase
        end
    end

    logic [TIME_BITS-1:0] w_d;
    logic                 w_env_ok;
    logic                 en;
    logic                 r_o_valid;

    assign w_d      = (r_dur == '0) ? TIME_BITS'(1) : r_dur;
    assign w_env_ok = (r_mc <= ONE) && (r_rue != '0) && (r_rue < r_rds) && (r_rds < ONE);
    assign en       = !r_o_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // Stage A: clamp time and divide into the path fraction.
    logic [TIME_BITS-1:0] w_t, w_tc;
    logic [VEL_W-1:0]     w_base_in;
    logic                 a_v;
    logic [UW-1:0]        a_u;
    logic [VEL_W-1:0]     a_base;

    assign w_t       = i_s_axis_tdata[TIME_BITS-1:0];
    assign w_base_in = i_s_axis_tdata[TIME_BITS +: VEL_W];
    assign w_tc      = (w_t > w_d) ? w_d : w_t;

    btf_div #(.NW(TIME_BITS + F), .DW(TIME_BITS), .QW(UW), .SW(VEL_W)) u_div_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_num   ({w_tc, {F{1'b0}}}),
        .i_den   (w_d),
        .i_side  (w_base_in),
        .o_valid (a_v),
        .o_quo   (a_u),
        .o_side  (a_base)
    );

    // Stage B: second-order terms and the feedforward division setup.
    logic [UW-1:0]   w_v;
    logic [2*UW-1:0] w_vv_f, w_uv_f, w_uu_f;
    logic            w_up, w_hold, w_skip;
    logic [UW-1:0]   w_cf_x, w_cf_den;
    logic [2*UW-1:0] w_cf_num;

    assign w_v    = ONE - a_u;
    assign w_vv_f = w_v * w_v;
    assign w_uv_f = a_u * w_v;
    assign w_uu_f = a_u * a_u;
    assign w_up   = a_u < r_rue;
    assign w_hold = !w_up && (a_u < r_rds);
    assign w_skip = !w_env_ok || w_hold;
    assign w_cf_x = w_up ? a_u : (ONE - a_u);
    assign w_cf_num = w_skip ? '0 : (w_cf_x * r_mc);
    assign w_cf_den = w_skip ? UW'(1) : (w_up ? r_rue : (ONE - r_rds));

    logic            r_b_v;
    logic [UW-1:0]   r_b_u, r_b_vf, r_b_vv, r_b_uv, r_b_uu;
    logic [VEL_W-1:0] r_b_base;
    logic [2*UW-1:0] r_b_cfn;
    logic [UW-1:0]   r_b_cfd;
    logic            r_b_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en) begin
            r_b_v <= a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_u    <= a_u;
            r_b_vf   <= w_v;
            r_b_vv   <= w_vv_f[F +: UW];
            r_b_uv   <= w_uv_f[F +: UW];
            r_b_uu   <= w_uu_f[F +: UW];
            r_b_base <= a_base;
            r_b_cfn  <= w_cf_num;
            r_b_cfd  <= w_cf_den;
            r_b_hold <= w_hold;
        end
    end

    // Stage C: basis weights and velocity terms.
    logic [2*UW-1:0]       w_b0_f, w_b1_f, w_b2_f, w_b3_f;
    logic signed [DIFW-1:0] w_d10, w_d21, w_d32;
    logic [UW-1:0]         w_b1_t, w_b2_t;

    assign w_b0_f = r_b_vv * r_b_vf;
    assign w_b1_f = r_b_vv * r_b_u;
    assign w_b2_f = r_b_uu * r_b_vf;
    assign w_b3_f = r_b_uu * r_b_u;
    assign w_b1_t = w_b1_f[F +: UW];
    assign w_b2_t = w_b2_f[F +: UW];
    assign w_d10  = DIFW'(r_p1) - DIFW'(r_p0);
    assign w_d21  = DIFW'(r_p2) - DIFW'(r_p1);
    assign w_d32  = DIFW'(r_p3) - DIFW'(r_p2);

    logic                  r_c_v;
    logic [BW-1:0]         r_c_b0, r_c_b1, r_c_b2, r_c_b3;
    logic signed [TW-1:0]  r_c_s0, r_c_s1, r_c_s2;
    logic [VEL_W-1:0]      r_c_base;
    logic [2*UW-1:0]       r_c_cfn;
    logic [UW-1:0]         r_c_cfd;
    logic                  r_c_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_b0   <= BW'(w_b0_f[F +: UW]);
            r_c_b1   <= BW'(w_b1_t) + {w_b1_t, 1'b0};
            r_c_b2   <= BW'(w_b2_t) + {w_b2_t, 1'b0};
            r_c_b3   <= BW'(w_b3_f[F +: UW]);
            r_c_s0   <= $signed({1'b0, r_b_vv}) * w_d10;
            r_c_s1   <= $signed({1'b0, r_b_uv}) * w_d21;
            r_c_s2   <= $signed({1'b0, r_b_uu}) * w_d32;
            r_c_base <= r_b_base;
            r_c_cfn  <= r_b_cfn;
            r_c_cfd  <= r_b_cfd;
            r_c_hold <= r_b_hold;
        end
    end

    // Stage D: position partial products and the velocity sum.
    logic signed [SSW-1:0] w_e0, w_e1, w_e2;

    assign w_e0 = SSW'(r_c_s0);
    assign w_e1 = SSW'(r_c_s1);
    assign w_e2 = SSW'(r_c_s2);

    logic                  r_d_v;
    logic signed [PPW-1:0] r_d_pp0, r_d_pp1, r_d_pp2, r_d_pp3;
    logic signed [SSW-1:0] r_d_s;
    logic [VEL_W-1:0]      r_d_base;
    logic [2*UW-1:0]       r_d_cfn;
    logic [UW-1:0]         r_d_cfd;
    logic                  r_d_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (en) begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_pp0  <= $signed({1'b0, r_c_b0}) * r_p0;
            r_d_pp1  <= $signed({1'b0, r_c_b1}) * r_p1;
            r_d_pp2  <= $signed({1'b0, r_c_b2}) * r_p2;
            r_d_pp3  <= $signed({1'b0, r_c_b3}) * r_p3;
            r_d_s    <= (w_e0 <<< 1) + w_e0 + (w_e1 <<< 2) + (w_e1 <<< 1)
                        + (w_e2 <<< 1) + w_e2;
            r_d_base <= r_c_base;
            r_d_cfn  <= r_c_cfn;
            r_d_cfd  <= r_c_cfd;
            r_d_hold <= r_c_hold;
        end
    end

    // Stage E: position and velocity magnitude.
    logic signed [PSW-1:0] w_psum, w_psh;
    logic [POS_W-1:0]      w_pos;
    logic                  w_pos_ok;

    assign w_psum   = PSW'(r_d_pp0) + PSW'(r_d_pp1) + PSW'(r_d_pp2) + PSW'(r_d_pp3);
    assign w_psh    = w_psum >>> F;
    assign w_pos_ok = (w_psh[PSW-1:POS_W-1] == '0) || (w_psh[PSW-1:POS_W-1] == '1);
    assign w_pos    = w_pos_ok ? w_psh[POS_W-1:0] : (w_psh[PSW-1] ? PMIN : PMAX);

    logic             r_e_v;
    logic [POS_W-1:0] r_e_pos;
    logic             r_e_neg;
    logic [SSW-1:0]   r_e_mag;
    logic [VEL_W-1:0] r_e_base;
    logic [2*UW-1:0]  r_e_cfn;
    logic [UW-1:0]    r_e_cfd;
    logic             r_e_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (en) begin
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_pos  <= w_pos;
            r_e_neg  <= r_d_s[SSW-1];
            r_e_mag  <= r_d_s[SSW-1] ? SSW'(-r_d_s) : SSW'(r_d_s);
            r_e_base <= r_d_base;
            r_e_cfn  <= r_d_cfn;
            r_e_cfd  <= r_d_cfd;
            r_e_hold <= r_d_hold;
        end
    end

    // Stage F: scale to m/s numerator.
    logic [MKW-1:0] w_mk;

    assign w_mk = (MKW'(r_e_mag) << 10) - (MKW'(r_e_mag) << 4) - (MKW'(r_e_mag) << 3);

    logic             r_f_v;
    logic [NW-1:0]    r_f_n;
    logic             r_f_neg;
    logic [POS_W-1:0] r_f_pos;
    logic [VEL_W-1:0] r_f_base;
    logic [2*UW-1:0]  r_f_cfn;
    logic [UW-1:0]    r_f_cfd;
    logic             r_f_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (en) begin
            r_f_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_n    <= w_mk[F +: NW];
            r_f_neg  <= r_e_neg;
            r_f_pos  <= r_e_pos;
            r_f_base <= r_e_base;
            r_f_cfn  <= r_e_cfn;
            r_f_cfd  <= r_e_cfd;
            r_f_hold <= r_e_hold;
        end
    end

    // Velocity and coefficient dividers run side by side.
    logic            w_ovf;
    logic            pv_v, cf_v;
    logic [VEL_W-1:0] pv_q, cf_q;
    logic [PVSW-1:0] pv_side;
    logic            cf_hold;

    assign w_ovf = (NW + 1 > TIME_BITS + VEL_W) ?
                   ((NW+1)'(r_f_n) >= ((NW+1)'(w_d) << VEL_W)) :
                   ((TIME_BITS+VEL_W)'(r_f_n) >= {w_d, {VEL_W{1'b0}}});

    btf_div #(.NW(NW), .DW(TIME_BITS), .QW(VEL_W), .SW(PVSW)) u_div_pv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_f_v),
        .i_num   (r_f_n),
        .i_den   (w_d),
        .i_side  ({w_ovf, r_f_neg, r_f_base, r_f_pos}),
        .o_valid (pv_v),
        .o_quo   (pv_q),
        .o_side  (pv_side)
    );

    btf_div #(.NW(2*UW), .DW(UW), .QW(VEL_W), .SW(1)) u_div_cf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_f_v),
        .i_num   (r_f_cfn),
        .i_den   (r_f_cfd),
        .i_side  (r_f_hold),
        .o_valid (cf_v),
        .o_quo   (cf_q),
        .o_side  (cf_hold)
    );

    // Stage G: saturate path velocity, pick the coefficient.
    logic             w_g_ovf, w_g_neg;
    logic [VEL_W-1:0] w_pv;

    assign w_g_ovf = pv_side[PVSW-1];
    assign w_g_neg = pv_side[PVSW-2];

    always_comb begin
        if (w_g_ovf) begin
            w_pv = w_g_neg ? VMIN : VMAX;
        end else if (!w_g_neg) begin
            w_pv = pv_q[VEL_W-1] ? VMAX : pv_q;
        end else begin
            w_pv = (pv_q > VMIN) ? VMIN : (~pv_q + VEL_W'(1));
        end
    end

    logic             r_g_v;
    logic [VEL_W-1:0] r_g_pv;
    logic [UW-1:0]    r_g_coef;
    logic [POS_W-1:0] r_g_pos;
    logic [VEL_W-1:0] r_g_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (en) begin
            r_g_v <= pv_v && cf_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_pv   <= w_pv;
            r_g_coef <= cf_hold ? r_mc : cf_q[UW-1:0];
            r_g_pos  <= pv_side[POS_W-1:0];
            r_g_base <= pv_side[POS_W +: VEL_W];
        end
    end

    // Stage H: coefficient times path velocity.
    logic                  r_h_v;
    logic signed [PRW-1:0] r_h_prod;
    logic [VEL_W-1:0]      r_h_pv;
    logic [POS_W-1:0]      r_h_pos;
    logic [VEL_W-1:0]      r_h_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
        end else if (en) begin
            r_h_v <= r_g_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_prod <= $signed({1'b0, r_g_coef}) * $signed(r_g_pv);
            r_h_pv   <= r_g_pv;
            r_h_pos  <= r_g_pos;
            r_h_base <= r_g_base;
        end
    end

    // Output stage: add base velocity and saturate, or pass base velocity alone when the envelope is invalid.
    logic signed [PRW-1:0] w_psh2;
    logic signed [VSW-1:0] w_vsum;
    logic                  w_v_ok;
    logic [VEL_W-1:0]      w_vsat;

    assign w_psh2 = r_h_prod >>> F;
    assign w_vsum = VSW'(w_psh2) + VSW'($signed(r_h_base));
    assign w_v_ok = (w_vsum[VSW-1:VEL_W-1] == '0) || (w_vsum[VSW-1:VEL_W-1] == '1);
    assign w_vsat = w_v_ok ? w_vsum[VEL_W-1:0] : (w_vsum[VSW-1] ? VMIN : VMAX);

    logic [POS_W-1:0] r_o_pos;
    logic [VEL_W-1:0] r_o_pv, r_o_vout;
    logic             r_o_env;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_h_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_pos  <= r_h_pos;
            r_o_pv   <= r_h_pv;
            r_o_vout <= w_env_ok ? w_vsat : r_h_base;
            r_o_env  <= w_env_ok;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = OUT_W'({r_o_vout, r_o_pv, r_o_pos});
    assign o_m_axis_tuser  = r_o_env;

    a_u_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_v |-> (r_b_u <= ONE))
        else $error("path fraction above one");

    a_div_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pv_v == cf_v)
        else $error("divider pipelines out of step");

    a_coef_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_g_v && w_env_ok) |-> (r_g_coef <= r_mc))
        else $error("coefficient above its peak");

endmodule
